/* sv/wcsc_pkg.sv */
// ----------------------------------------------------------------------------
// Wi-Fi credential checker package
// Shared constants, types and the name prefix table.
// ----------------------------------------------------------------------------
package wcsc_pkg;

  // Field layout and limits
  localparam int unsigned CountW       = 9;
  localparam logic [8:0]  CountMax     = 9'd511;
  localparam logic [7:0]  CapReset     = 8'd65;
  localparam logic [7:0]  PrintLow     = 8'd32;
  localparam logic [7:0]  DelCode      = 8'd127;
  localparam logic [7:0]  PassMinLen   = 8'd8;
  localparam logic [7:0]  PassMaxLen   = 8'd64;
  localparam logic [7:0]  NameMinLen   = 8'd11;
  localparam logic [7:0]  NameMaxLen   = 8'd32;
  localparam logic [8:0]  PrefixFirst  = 9'd2;
  localparam logic [8:0]  PrefixLast   = 9'd12;

  // Mode codes
  localparam logic MODE_NAME = 1'b0;
  localparam logic MODE_PASS = 1'b1;

  // Per-byte classification handed to the field tracker
  typedef struct packed {
    logic unprintable;
    logic non_hex;
    logic prefix_miss;
  } byte_class_t;

  // Result of one field
  typedef struct packed {
    logic       accepted;
    logic [7:0] string_length;
  } verdict_t;

  // Lower-case name prefix, one character per slot
  function automatic logic [7:0] prefix_char(input logic [3:0] slot);
    logic [7:0] c;
    unique case (slot)
      4'd0:    c = 8'h6f;
      4'd1:    c = 8'h73;
      4'd2:    c = 8'h6d;
      4'd3:    c = 8'h6f;
      4'd4:    c = 8'h70;
      4'd5:    c = 8'h6f;
      4'd6:    c = 8'h63;
      4'd7:    c = 8'h6b;
      4'd8:    c = 8'h65;
      4'd9:    c = 8'h74;
      4'd10:   c = 8'h33;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/wifi_credential_string_checker.sv */
// ----------------------------------------------------------------------------
// Wi-Fi credential string checker
// Checks a length-prefixed credential field byte by byte and reports a verdict.
// ----------------------------------------------------------------------------
// Output: the verdict is registered on the last byte's beat and appears in the next cycle.
// Throughput: one byte per cycle while the result side keeps up; the single result
//   register frees in the cycle its beat is taken, and input stalls while a result waits.
// Reset: clears field state and the result valid; capacity returns to 65.
module wifi_credential_string_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       mode,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [7:0] string_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] out_capacity
);

  logic [7:0]         capacity_reg;
  logic               in_beat;
  wcsc_pkg::verdict_t verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_reg <= wcsc_pkg::CapReset;
    end else if (cfg_valid && cfg_ready) begin
      capacity_reg <= out_capacity;
    end
  end

  wcsc_field_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .beat      (in_beat),
    .data_byte (data_byte),
    .mode      (mode),
    .last      (last),
    .capacity  (capacity_reg),
    .verdict   (verdict)
  );

  // Load the result on the last byte, release it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && last) begin
      accepted      <= verdict.accepted;
      string_length <= verdict.string_length;
    end
  end

endmodule

/* sv/wcsc_byte_class.sv */
// ----------------------------------------------------------------------------
// Byte classifier
// Flags a string byte as unprintable, non-hex or differing from the prefix.
// ----------------------------------------------------------------------------
module wcsc_byte_class (
  input  logic [7:0]                      data_byte,
  input  logic [wcsc_pkg::CountW-1:0]     byte_count,
  output wcsc_pkg::byte_class_t           cls
);

  logic [7:0]                  folded;
  logic [wcsc_pkg::CountW-1:0] slot_full;
  logic                        in_window;
  logic                        is_hex;

  // Fold upper case to lower case
  assign folded = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? data_byte + 8'd32 : data_byte;

  assign slot_full = byte_count - wcsc_pkg::PrefixFirst;
  assign in_window = (byte_count >= wcsc_pkg::PrefixFirst) &&
                     (byte_count <= wcsc_pkg::PrefixLast);

  assign is_hex = (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                  (data_byte >= 8'h61 && data_byte <= 8'h66) ||
                  (data_byte >= 8'h41 && data_byte <= 8'h46);

  // Classify the current beat
  assign cls.unprintable = (data_byte < wcsc_pkg::PrintLow) || (data_byte == wcsc_pkg::DelCode);
  assign cls.non_hex     = !is_hex;
  assign cls.prefix_miss = in_window && (folded != wcsc_pkg::prefix_char(slot_full[3:0]));

endmodule

/* sv/wcsc_field_tracker.sv */
// ----------------------------------------------------------------------------
// Field tracker
// Holds per-field state and forms the verdict on the final byte.
// ----------------------------------------------------------------------------
module wcsc_field_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beat,
  input  logic [7:0]            data_byte,
  input  logic                  mode,
  input  logic                  last,
  input  logic [7:0]            capacity,
  output wcsc_pkg::verdict_t    verdict
);

  logic [wcsc_pkg::CountW-1:0] byte_count;
  logic [7:0]                  declared_length;
  logic                        held_mode;
  logic                        header_bad;
  logic                        unprintable_seen;
  logic                        non_hex_seen;
  logic                        prefix_mismatch;

  logic [wcsc_pkg::CountW-1:0] byte_count_next;
  logic [7:0]                  declared_length_next;
  logic                        held_mode_next;
  logic                        header_bad_next;
  logic                        unprintable_seen_next;
  logic                        non_hex_seen_next;
  logic                        prefix_mismatch_next;

  wcsc_pkg::byte_class_t       cls;
  logic                        first_byte;
  logic                        len_byte;
  logic [8:0]                  len_plus2;
  logic                        ok_common;
  logic                        ok_pass;
  logic                        ok_name;

  wcsc_byte_class u_class (
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .cls        (cls)
  );

  assign first_byte = (byte_count == '0);
  assign len_byte   = (byte_count == 9'd1);

  // Next field state including the current beat
  always_comb begin
    byte_count_next       = (byte_count < wcsc_pkg::CountMax) ? byte_count + 9'd1 : byte_count;
    declared_length_next  = declared_length;
    held_mode_next        = held_mode;
    header_bad_next       = header_bad;
    unprintable_seen_next = unprintable_seen;
    non_hex_seen_next     = non_hex_seen;
    prefix_mismatch_next  = prefix_mismatch;
    if (first_byte) begin
      declared_length_next  = 8'd0;
      held_mode_next        = mode;
      header_bad_next       = (data_byte != 8'd0);
      unprintable_seen_next = 1'b0;
      non_hex_seen_next     = 1'b0;
      prefix_mismatch_next  = 1'b0;
    end else if (len_byte) begin
      declared_length_next  = data_byte;
    end else begin
      unprintable_seen_next = unprintable_seen | cls.unprintable;
      non_hex_seen_next     = non_hex_seen | cls.non_hex;
      prefix_mismatch_next  = prefix_mismatch | cls.prefix_miss;
    end
  end

  // Judge the field as it stands after this beat
  assign len_plus2 = {1'b0, declared_length_next} + 9'd2;
  assign ok_common = (byte_count_next >= 9'd2) && !header_bad_next &&
                     (byte_count_next == len_plus2) &&
                     (capacity > declared_length_next) && !unprintable_seen_next;
  assign ok_pass   = (declared_length_next >= wcsc_pkg::PassMinLen) &&
                     (declared_length_next <= wcsc_pkg::PassMaxLen) &&
                     !((declared_length_next == wcsc_pkg::PassMaxLen) && non_hex_seen_next);
  assign ok_name   = (declared_length_next >= wcsc_pkg::NameMinLen) &&
                     (declared_length_next <= wcsc_pkg::NameMaxLen) && !prefix_mismatch_next;

  assign verdict.accepted      = ok_common &&
                                 ((held_mode_next == wcsc_pkg::MODE_PASS) ? ok_pass : ok_name);
  assign verdict.string_length = declared_length_next;

  // Advance on each beat; drop back to a fresh field after the last byte
  always_ff @(posedge clk) begin
    if (rst || (beat && last)) begin
      byte_count       <= '0;
      declared_length  <= 8'd0;
      held_mode        <= 1'b0;
      header_bad       <= 1'b0;
      unprintable_seen <= 1'b0;
      non_hex_seen     <= 1'b0;
      prefix_mismatch  <= 1'b0;
    end else if (beat) begin
      byte_count       <= byte_count_next;
      declared_length  <= declared_length_next;
      held_mode        <= held_mode_next;
      header_bad       <= header_bad_next;
      unprintable_seen <= unprintable_seen_next;
      non_hex_seen     <= non_hex_seen_next;
      prefix_mismatch  <= prefix_mismatch_next;
    end
  end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Credential string checker testbench
// Sends length-prefixed credential fields one byte per beat and checks every
// verdict against a predictor running beside the block, or against the value
// that a directed row gives. A short directed table comes first. Random phases
// follow, each setting a capacity and idle and stall rates, some of them shared.
// One phase holds the result side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;

  // Name prefix, lower case, first character in the top byte
  localparam logic [87:0] NAME_HEAD   = 88'h6f736d6f706f636b657433;
  localparam int          HEAD_LEN    = 11;
  localparam logic [8:0]  COUNT_TOP   = 9'd511;
  localparam logic [7:0]  CTRL_TOP    = 8'd32;
  localparam logic [7:0]  DEL_CHAR    = 8'h7f;
  localparam logic [7:0]  PASS_MIN    = 8'd8;
  localparam logic [7:0]  PASS_MAX    = 8'd64;
  localparam logic [7:0]  NAME_MIN    = 8'd11;
  localparam logic [7:0]  NAME_MAX    = 8'd32;
  localparam logic [7:0]  CAP_AT_RST  = 8'd65;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_BEATS = 65;
  localparam int          NUM_PHASES  = 7;
  localparam int          DIR_ROWS    = 22;
  localparam int          LONG_KIND   = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       m;
    logic       l;
    logic       chk;
    logic       acc;
    logic [7:0] len;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'd0;
  logic       mode = wcsc_pkg::MODE_NAME;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [7:0] string_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  // Verdicts still owed by the block, oldest first
  wcsc_pkg::verdict_t verdict_q [$];
  int         err_count = 0;
  int         send_idle = 0;
  int         recv_stall = 0;
  int         hold_req = 0;
  int         hold_served = 0;
  int         phase_beats = 0;

  // Field tracker state of the predictor
  logic [8:0] seen_count = '0;
  logic [7:0] seen_len = '0;
  logic       seen_mode = wcsc_pkg::MODE_NAME;
  logic       hdr_bad = 1'b0;
  logic       ctrl_seen = 1'b0;
  logic       nonhex_seen = 1'b0;
  logic       head_miss = 1'b0;
  logic [7:0] cap_limit = CAP_AT_RST;

  wifi_credential_string_checker i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .mode         (mode),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .string_length(string_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .out_capacity (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] name_char(input int slot);
    return NAME_HEAD[87 - 8 * slot -: 8];
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Mostly printable ASCII, now and then a byte above 127
  function automatic logic [7:0] rand_text();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_hex();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return 8'("0" + d);
    if (d < 16) return 8'("a" + d - 10);
    return 8'("A" + d - 16);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic clear_field();
    seen_count  = '0;
    seen_len    = '0;
    seen_mode   = wcsc_pkg::MODE_NAME;
    hdr_bad     = 1'b0;
    ctrl_seen   = 1'b0;
    nonhex_seen = 1'b0;
    head_miss   = 1'b0;
  endtask

  // Advance the field tracker by one byte; give the verdict on the last byte
  task automatic predict_byte(input logic [7:0] b, input logic m, input logic l,
                              output logic got, output wcsc_pkg::verdict_t v);
    logic [8:0] slot;
    logic [7:0] folded;
    logic       ok;
    got = 1'b0;
    v   = '0;
    if (seen_count == 9'd0) begin
      clear_field();
      seen_mode = m;
      hdr_bad   = (b != 8'd0);
    end else if (seen_count == 9'd1) begin
      seen_len = b;
    end else begin
      slot   = seen_count - 9'd2;
      folded = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (b < CTRL_TOP || b == DEL_CHAR) ctrl_seen = 1'b1;
      if (!is_hex_digit(b)) nonhex_seen = 1'b1;
      if (slot < HEAD_LEN && folded != name_char(int'(slot))) head_miss = 1'b1;
    end
    if (seen_count != COUNT_TOP) seen_count = seen_count + 9'd1;
    if (l) begin
      ok = (seen_count >= 9'd2) && !hdr_bad && (seen_count == {1'b0, seen_len} + 9'd2) &&
           (cap_limit > seen_len) && !ctrl_seen;
      if (ok) begin
        if (seen_mode == wcsc_pkg::MODE_PASS) begin
          if (seen_len < PASS_MIN || seen_len > PASS_MAX) ok = 1'b0;
          else if (seen_len == PASS_MAX && nonhex_seen) ok = 1'b0;
        end else if (seen_len < NAME_MIN || seen_len > NAME_MAX || head_miss) begin
          ok = 1'b0;
        end
      end
      v.accepted      = ok;
      v.string_length = seen_len;
      got = 1'b1;
      clear_field();
    end
  endtask

  // Offer one byte beat, idling first at the sender's rate
  task automatic send_beat(input logic [7:0] b, input logic m, input logic l,
                           input logic typed, input wcsc_pkg::verdict_t typed_v);
    logic               got;
    wcsc_pkg::verdict_t v;
    if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    mode      <= m;
    last      <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, m, l, got, v);
    if (got) verdict_q.push_back(typed ? typed_v : v);
    phase_beats++;
  endtask

  // Build one field of the given kind and send it byte by byte
  //   0-3 name, 4-6 password, 7-8 broken field, 9 short noise, 10 overlong
  task automatic send_field(input int kind);
    logic [7:0] fb [$];
    logic [7:0] c;
    logic       md;
    logic       hex_only;
    int         len_b;
    int         i;
    int         k;
    fb = {};
    hex_only = 1'b0;
    if (kind >= 9) begin
      md    = 1'($urandom_range(0, 1));
      len_b = (kind == LONG_KIND) ? 520 : $urandom_range(1, 6);
      for (i = 0; i < len_b; i++) fb.push_back(8'($urandom_range(0, 255)));
      if (kind == LONG_KIND) fb[0] = 8'd0;
    end else begin
      if (kind < 4) md = wcsc_pkg::MODE_NAME;
      else if (kind < 7) md = wcsc_pkg::MODE_PASS;
      else md = 1'($urandom_range(0, 1));
      if (md == wcsc_pkg::MODE_NAME) begin
        len_b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(11, 32);
      end else begin
        case ($urandom_range(0, 7))
          0, 1:    len_b = 64;
          2: begin
            case ($urandom_range(0, 3))
              0:       len_b = 7;
              1:       len_b = 8;
              2:       len_b = 63;
              default: len_b = 65;
            endcase
          end
          default: len_b = $urandom_range(8, 64);
        endcase
        hex_only = 1'($urandom_range(0, 1));
      end
      fb.push_back(8'd0);
      fb.push_back(8'(len_b));
      for (i = 0; i < len_b; i++) begin
        if (md == wcsc_pkg::MODE_NAME && i < HEAD_LEN) begin
          c = name_char(i);
          if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
        end else if (hex_only) begin
          c = rand_hex();
        end else begin
          c = rand_text();
        end
        fb.push_back(c);
      end
      // Break a well-formed field in one place
      if (kind >= 7) begin
        case ($urandom_range(0, 4))
          0: fb[0] = 8'($urandom_range(1, 255));
          1: void'(fb.pop_back());
          2: fb.push_back(rand_text());
          3: begin
            c = ($urandom_range(0, 1) == 1) ? DEL_CHAR : 8'($urandom_range(0, 31));
            if (fb.size() > 2) fb[$urandom_range(2, fb.size() - 1)] = c;
            else fb.push_back(c);
          end
          default: begin
            if (fb.size() > 2) begin
              k = $urandom_range(2, (fb.size() - 1 < 12) ? fb.size() - 1 : 12);
              fb[k] = fb[k] ^ 8'h01;
            end
          end
        endcase
      end
    end
    for (i = 0; i < fb.size(); i++)
      send_beat(fb[i], (i == 0) ? md : 1'($urandom_range(0, 1)), i == fb.size() - 1,
                1'b0, '0);
  endtask

  // Drop valid and hold until every owed verdict has come out
  task automatic wait_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_limit = value;
  endtask

  // Result side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // Check each verdict beat against the oldest expectation
  always @(posedge clk) begin : verdict_check
    wcsc_pkg::verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict with none owed: accepted %0b length %0d",
                                  accepted, string_length));
      end else begin
        want = verdict_q.pop_front();
        if (accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, expected %0b (length %0d)",
                                    accepted, want.accepted, want.string_length));
        if (string_length !== want.string_length)
          report_mismatch($sformatf("string_length %0d, expected %0d",
                                    string_length, want.string_length));
      end
    end
  end

  initial begin : stimulus
    dir_row_t           dir_tab [0:DIR_ROWS-1];
    wcsc_pkg::verdict_t tv;
    int                 ph;
    int                 i;
    // byte, mode, last, typed check, accepted, length
    dir_tab = '{
      '{8'h00, wcsc_pkg::MODE_NAME, 1'b1, 1'b1, 1'b0, 8'd0},    // field of one zero byte
      '{8'h05, wcsc_pkg::MODE_PASS, 1'b1, 1'b1, 1'b0, 8'd0},    // one nonzero byte
      '{8'h00, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h00, wcsc_pkg::MODE_NAME, 1'b1, 1'b1, 1'b0, 8'd0},    // empty name
      '{8'h00, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h08, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},    // later mode ignored
      '{8'h61, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h42, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h7e, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},    // top printable
      '{8'h20, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},    // space
      '{8'h80, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},    // above 127 passes
      '{8'hff, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h39, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h5a, wcsc_pkg::MODE_NAME, 1'b1, 1'b0, 1'b0, 8'd0},
      '{8'h00, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h01, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h7f, wcsc_pkg::MODE_PASS, 1'b1, 1'b1, 1'b0, 8'd1},    // DEL
      '{8'h00, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h03, wcsc_pkg::MODE_NAME, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'h61, wcsc_pkg::MODE_NAME, 1'b1, 1'b1, 1'b0, 8'd3},    // field too short
      '{8'h00, wcsc_pkg::MODE_PASS, 1'b0, 1'b0, 1'b0, 8'd0},
      '{8'hff, wcsc_pkg::MODE_PASS, 1'b1, 1'b1, 1'b0, 8'd255}   // largest length byte
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Change the capacity only with the block idle
      if (ph != 0) begin
        wait_verdicts();
        case (ph)
          1:       write_capacity(8'd255);
          2:       write_capacity(8'd0);
          3:       write_capacity(8'd20);
          4:       write_capacity(8'd9);
          5:       write_capacity(8'($urandom_range(10, 70)));
          default: write_capacity(CAP_AT_RST);
        endcase
      end
      case (ph)
        1:       begin send_idle = 49; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 49; end
        3, 6:    begin send_idle = 38; recv_stall = 38; end
        default: begin send_idle = 0;  recv_stall = 0;  end
      endcase
      // Hold the result side off while bytes keep coming
      if (ph == 5) hold_req++;
      if (ph == 0) begin
        for (i = 0; i < DIR_ROWS; i++) begin
          tv.accepted      = dir_tab[i].acc;
          tv.string_length = dir_tab[i].len;
          send_beat(dir_tab[i].b, dir_tab[i].m, dir_tab[i].l, dir_tab[i].chk, tv);
        end
      end
      phase_beats = 0;
      if (ph == 4) send_field(LONG_KIND);
      while (phase_beats < PHASE_BEATS) send_field($urandom_range(0, 9));
    end

    wait_verdicts();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
